>>> rtl/core/tlbp_pkg.sv
`timescale 1ns / 1ps
package tlbp_pkg;

  // Operation codes
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ENTRY_COUNT    = 3'd0;
  localparam logic [2:0] REG_HISTORY_LENGTH = 3'd1;
  localparam logic [2:0] REG_TAG_WIDTH      = 3'd2;
  localparam logic [2:0] REG_GLOBAL_HISTORY = 3'd3;
  localparam logic [2:0] REG_GLOBAL_TABLE   = 3'd4;
  localparam logic [2:0] REG_SHARE_XOR      = 3'd5;

  // 2-bit counter value after reset or reallocation
  localparam logic [1:0] CTR_WNT = 2'b01;

  // Tag geometry
  localparam int TAG_BITS = 30;
  localparam logic [4:0] TAG_WIDTH_MAX = 5'd30;

  // Remainder unit: pc[31:2] walked DIV_BITS bits per step
  localparam int DIV_BITS  = 5;
  localparam int DIV_STEPS = 6;
  localparam logic [2:0] DIV_LAST = 3'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mem_read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_block;
  } status_t;

endpackage

>>> rtl/core/tlbp_ctrl.sv
`timescale 1ns / 1ps
module tlbp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tlbp_pkg::status_t status_i,
  output tlbp_pkg::cmd_t   cmd_o
);
  import tlbp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_last) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (!status_i.out_block) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_DIVIDE: cmd_o.div_step = 1'b1;
      ST_READ:   cmd_o.mem_read = 1'b1;
      ST_EXEC:   cmd_o.commit = !status_i.out_block;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/tlbp_dpath.sv
`timescale 1ns / 1ps
module tlbp_dpath #(
  parameter int MAX_ENTRIES = 32,
  parameter int MAX_HISTORY = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlbp_pkg::cmd_t    cmd_i,
  output tlbp_pkg::status_t status_o,
  input  logic [5:0]        entry_count_i,
  input  logic [3:0]        history_length_i,
  input  logic [4:0]        tag_width_i,
  input  logic              global_history_i,
  input  logic              global_table_i,
  input  logic              share_xor_i,
  input  logic              operation_i,
  input  logic [31:0]       branch_pc_i,
  input  logic [31:0]       resolved_target_i,
  input  logic              resolved_taken_i,
  input  logic [31:0]       earlier_prediction_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              predict_taken_o,
  output logic [31:0]       predicted_address_o,
  output logic              flush_o,
  output logic [31:0]       branch_count_o,
  output logic [31:0]       flush_count_o
);
  import tlbp_pkg::*;

  localparam int EW    = $clog2(MAX_ENTRIES + 1);
  localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NROWS = MAX_ENTRIES + 1;
  localparam int RAW   = $clog2(NROWS);
  localparam int HW    = MAX_HISTORY;
  localparam int SLOTS = 1 << MAX_HISTORY;
  localparam int ROWW  = 2 * SLOTS;
  localparam logic [RAW-1:0] SHARED_ROW = RAW'(MAX_ENTRIES);

  // Latched item
  logic        op_q;
  logic [31:0] pc_q, tgt_q, earlier_q;
  logic        taken_q;

  // Remainder unit
  logic [29:0]   quo_sh_q;
  logic [EW-1:0] rem_q, rem_d;
  logic [2:0]    step_q;
  logic [EW-1:0] eff;
  logic [EW:0]   trial;

  always_comb begin
    if (entry_count_i == 6'd0) eff = EW'(1);
    else if (32'(entry_count_i) > 32'(MAX_ENTRIES)) eff = EW'(MAX_ENTRIES);
    else eff = EW'(entry_count_i);
  end

  always_comb begin
    rem_d = rem_q;
    trial = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      trial = {rem_d, quo_sh_q[29 - b]};
      if (trial >= {1'b0, eff}) trial = trial - {1'b0, eff};
      rem_d = trial[EW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= operation_i;
      pc_q      <= branch_pc_i;
      tgt_q     <= resolved_target_i;
      taken_q   <= resolved_taken_i;
      earlier_q <= earlier_prediction_i;
      quo_sh_q  <= branch_pc_i[31:2];
      rem_q     <= '0;
      step_q    <= '0;
    end else if (cmd_i.div_step) begin
      quo_sh_q <= quo_sh_q << DIV_BITS;
      rem_q    <= rem_d;
      step_q   <= step_q + 3'd1;
    end
  end

  assign status_o.div_last = (step_q == DIV_LAST);

  logic [IW-1:0] idx;
  assign idx = rem_q[IW-1:0];

  // Entry stores
  logic [MAX_ENTRIES-1:0]  valid_q;
  logic [TAG_BITS-1:0]     tag_q    [MAX_ENTRIES];
  logic [31:0]             target_q [MAX_ENTRIES];
  logic [HW-1:0]           lhist_q  [MAX_ENTRIES];
  logic [HW-1:0]           ghist_q;

  // Counter rows: one per entry plus the shared row
  logic [ROWW-1:0]  ctr_mem [NROWS];
  logic [ROWW-1:0]  row_rd_q;
  logic [NROWS-1:0] row_valid_q;
  logic [RAW-1:0]   row_addr;

  assign row_addr = global_table_i ? SHARED_ROW : RAW'(idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) row_rd_q <= ctr_mem[row_addr];
  end

  // Derived config values
  logic [HW-1:0] hmask;
  logic [4:0]    twidth;
  logic [TAG_BITS-1:0] tag_now;
  always_comb begin
    if (history_length_i == 4'd0) hmask = HW'(1);
    else if (32'(history_length_i) > 32'(HW)) hmask = '1;
    else hmask = {HW{1'b1}} >> (HW - 32'(history_length_i));
    twidth  = (tag_width_i > TAG_WIDTH_MAX) ? TAG_WIDTH_MAX : tag_width_i;
    tag_now = pc_q[31:2] & ~({TAG_BITS{1'b1}} << twidth);
  end

  // Execute
  logic            hit, upd, realloc_row, flush_now;
  logic [HW-1:0]   hist_old, hist_new, slot;
  logic [ROWW-1:0] row_base, row_new;
  logic [1:0]      ctr, ctr_new;
  logic [31:0]     next_pc;

  always_comb begin
    upd  = (op_q == OP_UPDATE);
    hit  = valid_q[idx] && (tag_q[idx] == tag_now);
    if (global_history_i) hist_old = ghist_q;
    else if (upd && !hit) hist_old = '0;
    else hist_old = lhist_q[idx];
    hist_new = ((hist_old << 1) | HW'(taken_q)) & hmask;
    slot = hist_old & hmask;
    if (global_table_i && share_xor_i) slot = slot ^ (pc_q[HW+1:2] & hmask);
    realloc_row = upd && !hit && !global_table_i;
    if (!row_valid_q[row_addr] || realloc_row) row_base = {SLOTS{CTR_WNT}};
    else row_base = row_rd_q;
    ctr = row_base[2*slot +: 2];
    if (taken_q) ctr_new = (ctr == 2'd3) ? ctr : ctr + 2'd1;
    else ctr_new = (ctr == 2'd0) ? ctr : ctr - 2'd1;
    row_new = row_base;
    row_new[2*slot +: 2] = ctr_new;
    next_pc = pc_q + 32'd4;
    flush_now = taken_q ? (tgt_q != earlier_q) : (next_pc != earlier_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && upd) ctr_mem[row_addr] <= row_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      row_valid_q <= '0;
      ghist_q     <= '0;
      for (int e = 0; e < MAX_ENTRIES; e++) begin
        tag_q[e]    <= '0;
        target_q[e] <= '0;
        lhist_q[e]  <= '0;
      end
    end else if (cmd_i.commit && upd) begin
      valid_q[idx]  <= 1'b1;
      tag_q[idx]    <= tag_now;
      target_q[idx] <= tgt_q;
      row_valid_q[row_addr] <= 1'b1;
      if (global_history_i) ghist_q <= hist_new;
      else lhist_q[idx] <= hist_new;
    end
  end

  // Output register
  logic        out_valid_q;
  logic [31:0] bcount_q, fcount_q;

  assign status_o.out_block = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bcount_q    <= '0;
      fcount_q    <= '0;
    end else begin
      if (cmd_i.commit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i.commit && upd) begin
        bcount_q <= bcount_q + 32'd1;
        fcount_q <= fcount_q + 32'(flush_now);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (upd) begin
        predict_taken_o     <= 1'b0;
        predicted_address_o <= '0;
        flush_o             <= flush_now;
      end else begin
        predict_taken_o     <= hit && ctr[1];
        predicted_address_o <= (hit && ctr[1]) ? target_q[idx] : next_pc;
        flush_o             <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign branch_count_o = bcount_q;
  assign flush_count_o  = fcount_q;

endmodule

>>> rtl/core/two_level_branch_predictor_btb.sv
`timescale 1ns / 1ps
// Branch target buffer with a two-level direction predictor.
// Input channel (in_valid_i / in_stall_o) carries one predict or update per
// transfer; output channel (out_valid_o / out_stall_i) returns exactly one
// result per input item, in order.
// Steps: the item is taken while idle, a remainder unit forms the entry index
// (pc>>2 mod entry count, five bits a step), the counter-row memory is read,
// then the item executes and writes back; the next item is taken on the cycle
// after the result is loaded into the output register, so no new item is
// taken before the last one is through. The counter-row memory port (one
// read-modify-write of a full row per item) and the remainder loop set the
// time an item takes.
// Reset clears the configuration to its defaults, all entries, histories,
// counts, and the per-row valid bits that make unwritten counter rows read
// as weakly not taken; there is no clearing pass.
// A stalled result holds in the output register; the block finishes the next
// item's work and then waits in execute until that register frees up.
// Configuration is an APB-style port; the user writes only while idle (not enforced).
module two_level_branch_predictor_btb #(
  parameter int MAX_ENTRIES = 32,
  parameter int MAX_HISTORY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] branch_pc_i,
  input  logic [31:0] resolved_target_i,
  input  logic        resolved_taken_i,
  input  logic [31:0] earlier_prediction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        predict_taken_o,
  output logic [31:0] predicted_address_o,
  output logic        flush_o,
  output logic [31:0] branch_count_o,
  output logic [31:0] flush_count_o
);
  import tlbp_pkg::*;

  // Configuration registers
  logic [5:0] entry_count_q;
  logic [3:0] history_length_q;
  logic [4:0] tag_width_q;
  logic       global_history_q, global_table_q, share_xor_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q    <= 6'd32;
      history_length_q <= 4'd8;
      tag_width_q      <= 5'd30;
      global_history_q <= 1'b0;
      global_table_q   <= 1'b0;
      share_xor_q      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENTRY_COUNT:    entry_count_q    <= pwdata[5:0];
        REG_HISTORY_LENGTH: history_length_q <= pwdata[3:0];
        REG_TAG_WIDTH:      tag_width_q      <= pwdata[4:0];
        REG_GLOBAL_HISTORY: global_history_q <= pwdata[0];
        REG_GLOBAL_TABLE:   global_table_q   <= pwdata[0];
        REG_SHARE_XOR:      share_xor_q      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENTRY_COUNT:    prdata = 32'(entry_count_q);
      REG_HISTORY_LENGTH: prdata = 32'(history_length_q);
      REG_TAG_WIDTH:      prdata = 32'(tag_width_q);
      REG_GLOBAL_HISTORY: prdata = 32'(global_history_q);
      REG_GLOBAL_TABLE:   prdata = 32'(global_table_q);
      REG_SHARE_XOR:      prdata = 32'(share_xor_q);
      default:            prdata = '0;
    endcase
  end

  cmd_t    cmd;
  status_t status;

  tlbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tlbp_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_HISTORY (MAX_HISTORY)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .entry_count_i        (entry_count_q),
    .history_length_i     (history_length_q),
    .tag_width_i          (tag_width_q),
    .global_history_i     (global_history_q),
    .global_table_i       (global_table_q),
    .share_xor_i          (share_xor_q),
    .operation_i          (operation_i),
    .branch_pc_i          (branch_pc_i),
    .resolved_target_i    (resolved_target_i),
    .resolved_taken_i     (resolved_taken_i),
    .earlier_prediction_i (earlier_prediction_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .predict_taken_o      (predict_taken_o),
    .predicted_address_o  (predicted_address_o),
    .flush_o              (flush_o),
    .branch_count_o       (branch_count_o),
    .flush_count_o        (flush_count_o)
  );

endmodule

>>> rtl/core/tlbp_checker.sv
`timescale 1ns / 1ps
module tlbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        predict_taken_o,
  input logic        flush_o,
  input logic [31:0] branch_count_o,
  input logic [31:0] flush_count_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(predict_taken_o)
      && $stable(flush_o) && $stable(branch_count_o))
    else $error("stalled result changed");

  // Predicts never flush, updates never predict taken.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(predict_taken_o && flush_o))
    else $error("result is both predict and flush");

  // A flush result carries a flush count that just grew.
  a_flush_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) && flush_o && $past(rst_ni)
      |-> flush_count_o != $past(flush_count_o))
    else $error("flush count not advanced");

  // The input stalls in the cycle right after a transfer.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken back to back");

endmodule

bind two_level_branch_predictor_btb tlbp_checker u_tlbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .predict_taken_o (predict_taken_o),
  .flush_o         (flush_o),
  .branch_count_o  (branch_count_o),
  .flush_count_o   (flush_count_o)
);
